>>> rtl/batch_reorder_buffer_macros.svh
// Assertion macros shared by the batch reorder buffer RTL.
// No dependencies; the assertion bodies drop out when SYNTHESIS is defined.
`ifndef BATCH_REORDER_BUFFER_MACROS_SVH
`define BATCH_REORDER_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

`define BRB_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("batch reorder buffer check failed");

`define BRB_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("batch reorder buffer check failed");

`else

`define BRB_ASSERT_SAME(label, clk, rst_n, cond, prop)

`define BRB_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> rtl/bro_pkg.sv
// Package of the batch reorder buffer: default sizes, codes and the memory control type.
// No dependencies.
package bro_pkg;

    localparam int BATCH_WINDOW_DEF = 8;
    localparam int SLOT_DEPTH_DEF   = 8;
    localparam int HANDLE_BITS_DEF  = 16;
    localparam int MAX_RESULTS      = 64;
    localparam int BATCH_BITS       = 32;
    localparam int STATUS_BITS      = 2;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_RELEASED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

>>> rtl/bro_hold_mem.sv
// Holding memory for records of later batches: one write and one read port, registered read.
// Depends on bro_pkg for the memory control type.
module bro_hold_mem #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16
) (
    input  logic                  clk,
    input  bro_pkg::mem_ctl_t     ctl,
    input  logic [ADDR_BITS-1:0]  waddr,
    input  logic [DATA_BITS-1:0]  wdata,
    input  logic [ADDR_BITS-1:0]  raddr,
    output logic [DATA_BITS-1:0]  rdata
);
    import bro_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/batch_reorder_buffer.sv
// Top level of the batch reorder buffer: command port, slot bookkeeping and release sequencer.
// Depends on bro_pkg, bro_hold_mem and batch_reorder_buffer_macros.svh.
//
// An item is taken when start is high and busy is low. cmd selects a record arrival
// or a batch finish event for batch_num. A record of the current batch, a batch outside
// the window or a record for a full slot gives one result in the cycle after the item
// is taken, and busy stays low, so such items go at one per cycle. A record held for a
// later batch, or a finish mark for a later batch, gives no result and also leaves busy
// low. A finish of the current batch starts a release sequence: busy goes high, one
// held record is read from the holding memory per cycle, up to MAX_RESULTS per sequence,
// and each batch slot visited also takes a step to clear its count. A read record passes
// through the memory read register, a pending register and the output registers; the last
// result appears in the cycle in which busy drops. Each result is shown for one cycle with
// result_strobe high; last marks the final result of the item. The receiver cannot
// stall. Reset clears the current batch, the slot counts and the finish marks; the
// holding memory needs no clearing since only entries below a slot's count are read.
module batch_reorder_buffer #(
    parameter int BATCH_WINDOW = bro_pkg::BATCH_WINDOW_DEF,
    parameter int SLOT_DEPTH   = bro_pkg::SLOT_DEPTH_DEF,
    parameter int HANDLE_BITS  = bro_pkg::HANDLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [bro_pkg::BATCH_BITS-1:0] batch_num,
    input  logic [HANDLE_BITS-1:0]         record_handle,
    output logic                           result_strobe,
    output logic [HANDLE_BITS-1:0]         out_handle,
    output logic [bro_pkg::BATCH_BITS-1:0] out_batch,
    output logic [bro_pkg::STATUS_BITS-1:0] status,
    output logic                           last
);
    import bro_pkg::*;

    `include "batch_reorder_buffer_macros.svh"

    localparam int SW = (BATCH_WINDOW > 1) ? $clog2(BATCH_WINDOW) : 1;
    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam int AW = (BATCH_WINDOW * SLOT_DEPTH > 1) ? $clog2(BATCH_WINDOW * SLOT_DEPTH) : 1;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_RELEASE = 2'd1;
    localparam logic [1:0] S_DRAIN   = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [BATCH_BITS-1:0]  cur_batch_reg, cur_batch_next;
    logic [SW-1:0]          base_reg, base_next;
    logic [CW-1:0]          counts_reg [BATCH_WINDOW];
    logic [CW-1:0]          counts_next [BATCH_WINDOW];
    logic                   marks_reg [BATCH_WINDOW];
    logic                   marks_next [BATCH_WINDOW];
    logic [CW-1:0]          j_reg, j_next;
    logic [NW-1:0]          n_reg, n_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [BATCH_BITS-1:0]  rd_batch_reg, rd_batch_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [HANDLE_BITS-1:0] pend_handle_reg, pend_handle_next;
    logic [BATCH_BITS-1:0]  pend_batch_reg, pend_batch_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic [BATCH_BITS-1:0]  out_batch_reg, out_batch_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    mem_ctl_t               mctl;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [HANDLE_BITS-1:0] rdata;

    logic [BATCH_BITS-1:0]  delta;
    logic                   in_win;
    logic [SW:0]            slot_sum;
    logic [SW-1:0]          dslot;
    logic [SW-1:0]          base_inc;
    logic [CW-1:0]          cnt_cur;
    logic                   accept;

    bro_hold_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (HANDLE_BITS)
    ) u_hold_mem (
        .clk   (clk),
        .ctl   (mctl),
        .waddr (waddr),
        .wdata (record_handle),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign delta  = batch_num - cur_batch_reg;
    assign in_win = (delta < BATCH_BITS'(BATCH_WINDOW));

    always_comb
    begin
        slot_sum = {1'b0, base_reg} + {1'b0, delta[SW-1:0]};
        if (slot_sum >= (SW+1)'(BATCH_WINDOW))
        begin
            slot_sum = slot_sum - (SW+1)'(BATCH_WINDOW);
        end
        dslot = slot_sum[SW-1:0];
        if (base_reg == SW'(BATCH_WINDOW - 1))
        begin
            base_inc = '0;
        end
        else
        begin
            base_inc = base_reg + SW'(1);
        end
    end

    assign cnt_cur = counts_reg[base_reg];
    assign waddr   = AW'(dslot) * AW'(SLOT_DEPTH) + AW'(counts_reg[dslot]);
    assign raddr   = AW'(base_reg) * AW'(SLOT_DEPTH) + AW'(j_reg);

    always_comb
    begin
        state_next       = state_reg;
        cur_batch_next   = cur_batch_reg;
        base_next        = base_reg;
        counts_next      = counts_reg;
        marks_next       = marks_reg;
        j_next           = j_reg;
        n_next           = n_reg;
        rd_valid_next    = 1'b0;
        rd_batch_next    = cur_batch_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        pend_batch_next  = pend_batch_reg;
        out_valid_next   = 1'b0;
        out_handle_next  = out_handle_reg;
        out_batch_next   = out_batch_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        mctl             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!in_win)
                    begin
                        out_valid_next  = 1'b1;
                        out_handle_next = (cmd == CMD_FINISH) ? '0 : record_handle;
                        out_batch_next  = batch_num;
                        out_status_next = ST_OUTSIDE;
                        out_last_next   = 1'b1;
                    end
                    else if (cmd == CMD_RECORD)
                    begin
                        if (delta == '0)
                        begin
                            out_valid_next  = 1'b1;
                            out_handle_next = record_handle;
                            out_batch_next  = batch_num;
                            out_status_next = ST_RELEASED;
                            out_last_next   = 1'b1;
                        end
                        else if (counts_reg[dslot] >= CW'(SLOT_DEPTH))
                        begin
                            out_valid_next  = 1'b1;
                            out_handle_next = record_handle;
                            out_batch_next  = batch_num;
                            out_status_next = ST_FULL;
                            out_last_next   = 1'b1;
                        end
                        else
                        begin
                            mctl.wr_en         = 1'b1;
                            counts_next[dslot] = counts_reg[dslot] + CW'(1);
                        end
                    end
                    else if (delta != '0)
                    begin
                        marks_next[dslot] = 1'b1;
                    end
                    else
                    begin
                        cur_batch_next = cur_batch_reg + BATCH_BITS'(1);
                        base_next      = base_inc;
                        j_next         = '0;
                        n_next         = '0;
                        state_next     = S_RELEASE;
                    end
                end
            end
            S_RELEASE:
            begin
                if (j_reg < cnt_cur)
                begin
                    j_next = j_reg + CW'(1);
                    if (n_reg < NW'(MAX_RESULTS))
                    begin
                        mctl.rd_en    = 1'b1;
                        rd_valid_next = 1'b1;
                        n_next        = n_reg + NW'(1);
                    end
                end
                else
                begin
                    counts_next[base_reg] = '0;
                    j_next                = '0;
                    if (marks_reg[base_reg])
                    begin
                        marks_next[base_reg] = 1'b0;
                        cur_batch_next       = cur_batch_reg + BATCH_BITS'(1);
                        base_next            = base_inc;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!rd_valid_reg)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_handle_next = pend_handle_reg;
                        out_batch_next  = pend_batch_reg;
                        out_status_next = ST_RELEASED;
                        out_last_next   = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rd_valid_reg)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_handle_next = pend_handle_reg;
                out_batch_next  = pend_batch_reg;
                out_status_next = ST_RELEASED;
                out_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_handle_next = rdata;
            pend_batch_next  = rd_batch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_batch_reg  <= '0;
            base_reg       <= '0;
            j_reg          <= '0;
            n_reg          <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < BATCH_WINDOW; i++)
            begin
                counts_reg[i] <= '0;
                marks_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cur_batch_reg  <= cur_batch_next;
            base_reg       <= base_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            counts_reg     <= counts_next;
            marks_reg      <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_batch_reg    <= rd_batch_next;
        pend_handle_reg <= pend_handle_next;
        pend_batch_reg  <= pend_batch_next;
        out_handle_reg  <= out_handle_next;
        out_batch_reg   <= out_batch_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    assign result_strobe = out_valid_reg;
    assign out_handle    = out_handle_reg;
    assign out_batch     = out_batch_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

    `BRB_ASSERT_SAME(a_idle_no_read, clk, rst_n, !busy, !rd_valid_reg && !pend_valid_reg)
    `BRB_ASSERT_SAME(a_read_in_range, clk, rst_n, mctl.rd_en,
        (state_reg == S_RELEASE) && (j_reg < cnt_cur))
    `BRB_ASSERT_SAME(a_result_bound, clk, rst_n, 1'b1, n_reg <= NW'(MAX_RESULTS))
    `BRB_ASSERT_SAME(a_more_follows, clk, rst_n, out_valid_reg && !out_last_reg,
        pend_valid_reg && busy)
    `BRB_ASSERT_NEXT(a_read_lands, clk, rst_n, mctl.rd_en, pend_valid_next)

endmodule

>>> dv/batch_reorder_buffer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of batch_reorder_buffer: directed rows, then random items; each
// result is checked against the bench's in-order release predictor or a row's typed value.
// Depends on bro_pkg and the batch_reorder_buffer RTL.
module batch_reorder_buffer_tb;

    import bro_pkg::*;

    localparam int WIN      = BATCH_WINDOW_DEF;
    localparam int DEPTH    = SLOT_DEPTH_DEF;
    localparam int HW       = HANDLE_BITS_DEF;
    localparam int CLK_HALF = 10;
    localparam int N_RANDOM = 345;

    typedef struct {
        logic [HW-1:0]          handle;
        logic [BATCH_BITS-1:0]  batch;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } result_t;

    typedef struct {
        logic                   op;
        logic [BATCH_BITS-1:0]  bid;
        logic [HW-1:0]          hnd;
        bit                     typed;
        logic [HW-1:0]          x_handle;
        logic [BATCH_BITS-1:0]  x_batch;
        logic [STATUS_BITS-1:0] x_status;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    cmd = CMD_RECORD;
    logic [BATCH_BITS-1:0]   batch_num = '0;
    logic [HW-1:0]           record_handle = '0;
    logic                    busy;
    logic                    result_strobe;
    logic [HW-1:0]           out_handle;
    logic [BATCH_BITS-1:0]   out_batch;
    logic [STATUS_BITS-1:0]  status;
    logic                    last;

    logic [BATCH_BITS-1:0]   cur_batch;
    int unsigned             base_slot;
    logic [HW-1:0]           held_slots [WIN][DEPTH];
    int unsigned             slot_fill [WIN];
    bit                      batch_done [WIN];

    result_t                 step_results [$];
    result_t                 due_results [$];
    stim_row_t               directed [25];

    int                      n_errors = 0;
    int                      n_items = 0;
    int                      n_released = 0;
    int                      n_outside = 0;
    int                      n_full = 0;
    bit                      no_gaps = 1'b0;

    batch_reorder_buffer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .batch_num     (batch_num),
        .record_handle (record_handle),
        .result_strobe (result_strobe),
        .out_handle    (out_handle),
        .out_batch     (out_batch),
        .status        (status),
        .last          (last)
    );

    always #CLK_HALF clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 50)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic result_t make_result(input logic [HW-1:0] h,
                                            input logic [BATCH_BITS-1:0] b,
                                            input logic [STATUS_BITS-1:0] s);
        result_t r;
        r.handle = h;
        r.batch  = b;
        r.status = s;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic void advance_batch();
        cur_batch = cur_batch + 1'b1;
        base_slot = (base_slot + 1) % WIN;
    endfunction

    function automatic void reorder_step(input logic op, input logic [BATCH_BITS-1:0] bid,
                                         input logic [HW-1:0] hnd);
        logic [BATCH_BITS-1:0] delta;
        int unsigned           slot;
        step_results.delete();
        delta = bid - cur_batch;
        if (delta >= WIN)
        begin
            step_results.push_back(make_result((op == CMD_FINISH) ? '0 : hnd, bid, ST_OUTSIDE));
        end
        else if (op == CMD_RECORD)
        begin
            slot = (base_slot + delta) % WIN;
            if (delta == 0)
            begin
                step_results.push_back(make_result(hnd, bid, ST_RELEASED));
            end
            else if (slot_fill[slot] >= DEPTH)
            begin
                step_results.push_back(make_result(hnd, bid, ST_FULL));
            end
            else
            begin
                held_slots[slot][slot_fill[slot]] = hnd;
                slot_fill[slot]++;
            end
        end
        else if (delta != 0)
        begin
            batch_done[(base_slot + delta) % WIN] = 1'b1;
        end
        else
        begin
            advance_batch();
            for (int step = 0; step < WIN; step++)
            begin
                slot = base_slot;
                for (int j = 0; j < slot_fill[slot]; j++)
                begin
                    step_results.push_back(make_result(held_slots[slot][j], cur_batch,
                                                       ST_RELEASED));
                end
                slot_fill[slot] = 0;
                if (!batch_done[slot])
                begin
                    break;
                end
                batch_done[slot] = 1'b0;
                advance_batch();
            end
        end
        if (step_results.size() > 0)
        begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic send_item(input stim_row_t row);
        int      gap;
        result_t typed_res;
        gap = no_gaps ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        cmd           <= row.op;
        batch_num     <= row.bid;
        record_handle <= row.hnd;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        n_items++;
        reorder_step(row.op, row.bid, row.hnd);
        if (row.typed)
        begin
            typed_res = make_result(row.x_handle, row.x_batch, row.x_status);
            typed_res.last = 1'b1;
            due_results.push_back(typed_res);
        end
        else
        begin
            foreach (step_results[k])
            begin
                due_results.push_back(step_results[k]);
            end
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    function automatic stim_row_t random_row();
        stim_row_t   row;
        int unsigned sel;
        sel       = $urandom_range(0, 99);
        row.hnd   = HW'($urandom);
        row.typed = 1'b0;
        row.x_handle = '0;
        row.x_batch  = '0;
        row.x_status = ST_RELEASED;
        row.op    = ($urandom_range(0, 1) == 1) ? CMD_FINISH : CMD_RECORD;
        if (sel < 50)
        begin
            row.op  = CMD_RECORD;
            row.bid = cur_batch + $urandom_range(0, WIN - 1);
        end
        else if (sel < 62)
        begin
            row.op  = CMD_FINISH;
            row.bid = cur_batch + $urandom_range(1, WIN - 1);
        end
        else if (sel < 80)
        begin
            row.op  = CMD_FINISH;
            row.bid = cur_batch;
        end
        else if (sel < 85)
        begin
            row.bid = cur_batch + $urandom_range(WIN, 2 * WIN);
        end
        else if (sel < 90)
        begin
            row.bid = cur_batch - $urandom_range(1, WIN);
        end
        else
        begin
            row.bid = $urandom;
        end
        return row;
    endfunction

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && result_strobe)
        begin
            case (status)
                ST_RELEASED: n_released++;
                ST_OUTSIDE:  n_outside++;
                ST_FULL:     n_full++;
                default:     ;
            endcase
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result handle %h batch %h status %0d",
                                          out_handle, out_batch, status));
            end
            else
            begin
                exp_res = due_results.pop_front();
                if (out_handle !== exp_res.handle || out_batch !== exp_res.batch ||
                    status !== exp_res.status || last !== exp_res.last)
                begin
                    report_mismatch($sformatf(
                        "got handle %h batch %h status %0d last %b, want %h %h %0d %b",
                        out_handle, out_batch, status, last, exp_res.handle,
                        exp_res.batch, exp_res.status, exp_res.last));
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        cur_batch = '0;
        base_slot = 0;
        for (int s = 0; s < WIN; s++)
        begin
            slot_fill[s]  = 0;
            batch_done[s] = 1'b0;
        end

        directed[0]  = '{CMD_RECORD, 32'h0000_0000, 16'hFFFF, 1'b1, 16'hFFFF, 32'h0, ST_RELEASED};
        directed[1]  = '{CMD_RECORD, 32'h0000_0000, 16'h0000, 1'b1, 16'h0000, 32'h0, ST_RELEASED};
        directed[2]  = '{CMD_RECORD, 32'hFFFF_FFFF, 16'hA5A5, 1'b1, 16'hA5A5, 32'hFFFF_FFFF,
                         ST_OUTSIDE};
        directed[3]  = '{CMD_FINISH, 32'h0000_0008, 16'h1234, 1'b1, 16'h0000, 32'h8, ST_OUTSIDE};
        directed[4]  = '{CMD_RECORD, 32'h0000_0007, 16'h0001, 1'b0, '0, '0, ST_RELEASED};
        directed[5]  = '{CMD_RECORD, 32'h0000_0001, 16'h0101, 1'b0, '0, '0, ST_RELEASED};
        directed[6]  = '{CMD_RECORD, 32'h0000_0001, 16'h0202, 1'b0, '0, '0, ST_RELEASED};
        directed[7]  = '{CMD_RECORD, 32'h0000_0001, 16'h0404, 1'b0, '0, '0, ST_RELEASED};
        directed[8]  = '{CMD_RECORD, 32'h0000_0001, 16'h0808, 1'b0, '0, '0, ST_RELEASED};
        directed[9]  = '{CMD_RECORD, 32'h0000_0001, 16'h1010, 1'b0, '0, '0, ST_RELEASED};
        directed[10] = '{CMD_RECORD, 32'h0000_0001, 16'h2020, 1'b0, '0, '0, ST_RELEASED};
        directed[11] = '{CMD_RECORD, 32'h0000_0001, 16'h4040, 1'b0, '0, '0, ST_RELEASED};
        directed[12] = '{CMD_RECORD, 32'h0000_0001, 16'h8080, 1'b0, '0, '0, ST_RELEASED};
        directed[13] = '{CMD_RECORD, 32'h0000_0001, 16'h5A5A, 1'b1, 16'h5A5A, 32'h1, ST_FULL};
        directed[14] = '{CMD_FINISH, 32'h0000_0002, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[15] = '{CMD_FINISH, 32'h0000_0002, 16'hFFFF, 1'b0, '0, '0, ST_RELEASED};
        directed[16] = '{CMD_FINISH, 32'h0000_0000, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[17] = '{CMD_FINISH, 32'h0000_0001, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[18] = '{CMD_RECORD, 32'h0000_0003, 16'h8000, 1'b1, 16'h8000, 32'h3, ST_RELEASED};
        directed[19] = '{CMD_FINISH, 32'h0000_0005, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[20] = '{CMD_RECORD, 32'h0000_0006, 16'h7FFF, 1'b0, '0, '0, ST_RELEASED};
        directed[21] = '{CMD_FINISH, 32'h0000_0003, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[22] = '{CMD_FINISH, 32'h0000_0004, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[23] = '{CMD_FINISH, 32'h0000_0006, 16'h0000, 1'b0, '0, '0, ST_RELEASED};
        directed[24] = '{CMD_RECORD, 32'h0000_0002, 16'h1111, 1'b1, 16'h1111, 32'h2, ST_OUTSIDE};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i]);
        end
        drain_results();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 40 == 0)
            begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            if (i == N_RANDOM / 2)
            begin
                drain_results();
            end
            send_item(random_row());
        end

        start <= 1'b0;
        @(posedge clk);
        wait_cycles = 0;
        while ((due_results.size() != 0 || busy) && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);
        while (due_results.size() != 0)
        begin
            void'(due_results.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("Sent %0d items: %0d records released, %0d outside the window, %0d slot full.",
                 n_items, n_released, n_outside, n_full);
        if (n_errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> batch_reorder_buffer.f
+incdir+rtl
rtl/bro_pkg.sv
rtl/bro_hold_mem.sv
rtl/batch_reorder_buffer.sv
dv/batch_reorder_buffer_tb.sv
